>>> hdl/biad_pkg.sv
// shared constants and controller/datapath interface types of the area downsampler
`default_nettype none
package biad_pkg;
	localparam int SRC_MAX    = 4096;
	localparam int TARGET_MAX = 64;

	localparam int N_W    = 13; // holds 1..SRC_MAX
	localparam int POS_W  = 12; // source position and remainder, 0..SRC_MAX-1
	localparam int T_W    = 7;  // holds 1..TARGET_MAX
	localparam int CELL_W = 6;  // cell index, 0..TARGET_MAX-1
	localparam int ACC_W  = 25;
	localparam int COV_W  = 17;
	localparam int PROD_W = 20; // row boundary products y*t and r*n
	localparam int AREA_W = 14; // one pixel's overlap with one cell
	localparam int ADDR_W = CELL_W + 1;
	localparam int DEPTH  = 2 * TARGET_MAX;
	localparam int DCNT_W = 5;

	localparam logic       REG_SRC_SIZE    = 1'b0;
	localparam logic       REG_TARGET_SIZE = 1'b1;
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(COV_W - 1);

	typedef struct packed {
		logic upd_rd;
		logic upd_wr;
		logic adv;
		logic emit_rd;
		logic emit_ld;
		logic div_step;
		logic show;
		logic out_take;
		logic row_step;
	} cmd_t;

	typedef struct packed {
		logic pix;
		logic k_last;
		logic row_end;
		logic emit_ok;
		logic div_done;
		logic col_last;
	} sts_t;
endpackage
`default_nettype wire

>>> hdl/biad_ctrl.sv
// sequencer for pixel updates, row emission and division
`default_nettype none
module biad_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          out_stall,
	input  wire biad_pkg::sts_t sts,
	output biad_pkg::cmd_t     cmd,
	output logic               in_stall
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_URD  = 4'd1;
	localparam logic [3:0] S_UWR  = 4'd2;
	localparam logic [3:0] S_ADV  = 4'd3;
	localparam logic [3:0] S_ERD  = 4'd4;
	localparam logic [3:0] S_ELD  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_OUT  = 4'd7;
	localparam logic [3:0] S_ROW  = 4'd8;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = sts.pix ? S_URD : S_ADV;
			end
			S_URD: begin
				cmd.upd_rd = 1'b1;
				state_d    = S_UWR;
			end
			S_UWR: begin
				cmd.upd_wr = 1'b1;
				state_d    = sts.k_last ? S_ADV : S_URD;
			end
			S_ADV: begin
				cmd.adv = 1'b1;
				if (!sts.row_end) state_d = S_IDLE;
				else state_d = sts.emit_ok ? S_ERD : S_ROW;
			end
			S_ERD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_ELD;
			end
			S_ELD: begin
				cmd.emit_ld = 1'b1;
				state_d     = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = S_OUT;
			end
			S_OUT: begin
				cmd.show = 1'b1;
				if (!out_stall) begin
					cmd.out_take = 1'b1;
					state_d      = sts.col_last ? S_ROW : S_ERD;
				end
			end
			S_ROW: begin
				cmd.row_step = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

>>> hdl/biad_dp.sv
// datapath: position tracking, accumulator memory, coverage divider, result register
`default_nettype none
module biad_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic                               cfg_index,
	input  wire logic [biad_pkg::N_W-1:0]           cfg_data,
	input  wire logic                               pixel,
	input  wire biad_pkg::cmd_t                     cmd,
	output biad_pkg::sts_t                          sts,
	output logic                                    out_valid,
	output logic [biad_pkg::CELL_W-1:0]             cell_x,
	output logic [biad_pkg::CELL_W-1:0]             cell_y,
	output logic [biad_pkg::ACC_W-1:0]              area_sum,
	output logic [biad_pkg::COV_W-1:0]              coverage,
	output logic                                    row_done,
	output logic                                    frame_done
);
	localparam int N_W    = biad_pkg::N_W;
	localparam int POS_W  = biad_pkg::POS_W;
	localparam int T_W    = biad_pkg::T_W;
	localparam int CELL_W = biad_pkg::CELL_W;
	localparam int ACC_W  = biad_pkg::ACC_W;
	localparam int COV_W  = biad_pkg::COV_W;
	localparam int PROD_W = biad_pkg::PROD_W;
	localparam int AREA_W = biad_pkg::AREA_W;
	localparam int ADDR_W = biad_pkg::ADDR_W;
	localparam int DEPTH  = biad_pkg::DEPTH;
	localparam int DCNT_W = biad_pkg::DCNT_W;

	logic [N_W-1:0]    src_q;
	logic [T_W-1:0]    tgt_q;
	logic [N_W-1:0]    n_eff;
	logic [T_W-1:0]    t_eff;
	logic [ACC_W-1:0]  nn_q;

	logic [POS_W-1:0]  xcnt_q, xrem_q, ycnt_q, yrem_q;
	logic [CELL_W-1:0] cx_q, cy_q, col_q;
	logic [T_W-1:0]    r_q;
	logic [PROD_W-1:0] py_q, pr_q;
	logic [1:0]        k_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [ACC_W-1:0]  mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [ACC_W-1:0]  rd_q;
	logic              rdv_q;
	logic [ACC_W-1:0]  rd_val;

	logic [ACC_W-1:0]  rem_q;
	logic [COV_W-1:0]  quo_q;
	logic [ACC_W-1:0]  area_q;

	// effective sizes after clamping
	always_comb begin
		if (src_q == '0) n_eff = N_W'(1);
		else if (src_q > N_W'(biad_pkg::SRC_MAX)) n_eff = N_W'(biad_pkg::SRC_MAX);
		else n_eff = src_q;
		if (tgt_q == '0) t_eff = T_W'(1);
		else if (tgt_q > T_W'(biad_pkg::TARGET_MAX)) t_eff = T_W'(biad_pkg::TARGET_MAX);
		else t_eff = tgt_q;
		if ({{(N_W-T_W){1'b0}}, t_eff} > n_eff) t_eff = n_eff[T_W-1:0];
	end

	// pixel split into first cell and two overlaps, per axis
	logic [N_W-1:0]  xdiff, ydiff;
	logic [T_W-1:0]  wx0, wx1, hy0, hy1;
	always_comb begin
		xdiff = n_eff - {1'b0, xrem_q};
		ydiff = n_eff - {1'b0, yrem_q};
		wx0   = (xdiff > {{(N_W-T_W){1'b0}}, t_eff}) ? t_eff : xdiff[T_W-1:0];
		hy0   = (ydiff > {{(N_W-T_W){1'b0}}, t_eff}) ? t_eff : ydiff[T_W-1:0];
		wx1   = t_eff - wx0;
		hy1   = t_eff - hy0;
	end

	// update of one of the four cells a set pixel touches
	logic [T_W-1:0]    wk, hk, col_k, row_k;
	logic [AREA_W-1:0] area_k;
	logic              in_rng;
	logic [ADDR_W-1:0] upd_addr, emit_addr, raddr;
	always_comb begin
		wk       = k_q[0] ? wx1 : wx0;
		hk       = k_q[1] ? hy1 : hy0;
		col_k    = {1'b0, cx_q} + T_W'(k_q[0]);
		row_k    = {1'b0, cy_q} + T_W'(k_q[1]);
		in_rng   = (col_k < t_eff) && (row_k < t_eff);
		area_k   = in_rng ? AREA_W'(wk * hk) : '0;
		upd_addr = {row_k[0], col_k[CELL_W-1:0]};
		emit_addr = {r_q[0], col_q};
		raddr    = cmd.emit_rd ? emit_addr : upd_addr;
		rd_val   = rdv_q ? rd_q : '0;
	end

	logic [N_W:0]      xsum, ysum;
	logic              row_end, frame_last, col_last, restart;
	logic [PROD_W-1:0] py_next, pr_next;
	always_comb begin
		xsum       = {2'b0, xrem_q} + {{(N_W+1-T_W){1'b0}}, t_eff};
		ysum       = {2'b0, yrem_q} + {{(N_W+1-T_W){1'b0}}, t_eff};
		row_end    = {1'b0, xcnt_q} == (n_eff - N_W'(1));
		frame_last = {1'b0, ycnt_q} == (n_eff - N_W'(1));
		col_last   = {1'b0, col_q} == (t_eff - T_W'(1));
		py_next    = py_q + PROD_W'(t_eff);
		pr_next    = pr_q + PROD_W'(n_eff);
		restart    = cfg_we || (cmd.row_step && frame_last);
	end

	assign sts.pix      = pixel;
	assign sts.k_last   = (k_q == 2'd3);
	assign sts.row_end  = row_end;
	assign sts.emit_ok  = (r_q < t_eff) && (py_next >= pr_next);
	assign sts.div_done = (dcnt_q == biad_pkg::DIV_LAST);
	assign sts.col_last = col_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q  <= N_W'(1024);
			tgt_q  <= T_W'(32);
			xcnt_q <= '0; xrem_q <= '0; cx_q <= '0;
			ycnt_q <= '0; yrem_q <= '0; cy_q <= '0;
			r_q    <= '0; py_q <= '0; pr_q <= '0;
			col_q  <= '0; k_q <= '0; dcnt_q <= '0;
			vld_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == biad_pkg::REG_SRC_SIZE) src_q <= cfg_data;
				else tgt_q <= cfg_data[T_W-1:0];
			end
			if (cmd.upd_wr) begin
				k_q <= k_q + 2'd1;
				vld_q[upd_addr] <= 1'b1;
			end
			if (cmd.adv) begin
				if (row_end) begin
					xcnt_q <= '0; xrem_q <= '0; cx_q <= '0;
				end else begin
					xcnt_q <= xcnt_q + POS_W'(1);
					if (xsum >= {1'b0, n_eff}) begin
						xrem_q <= POS_W'(xsum - {1'b0, n_eff});
						cx_q   <= cx_q + CELL_W'(1);
					end else begin
						xrem_q <= xsum[POS_W-1:0];
					end
				end
			end
			if (cmd.emit_ld) vld_q[emit_addr] <= 1'b0;
			if (cmd.emit_ld) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + DCNT_W'(1);
			if (cmd.out_take) begin
				if (col_last) begin
					col_q <= '0;
					r_q   <= r_q + T_W'(1);
					pr_q  <= pr_next;
				end else begin
					col_q <= col_q + CELL_W'(1);
				end
			end
			if (cmd.row_step && !frame_last) begin
				ycnt_q <= ycnt_q + POS_W'(1);
				py_q   <= py_next;
				if (ysum >= {1'b0, n_eff}) begin
					yrem_q <= POS_W'(ysum - {1'b0, n_eff});
					cy_q   <= cy_q + CELL_W'(1);
				end else begin
					yrem_q <= ysum[POS_W-1:0];
				end
			end
			if (restart) begin
				xcnt_q <= '0; xrem_q <= '0; cx_q <= '0;
				ycnt_q <= '0; yrem_q <= '0; cy_q <= '0;
				r_q    <= '0; py_q <= '0; pr_q <= '0;
				col_q  <= '0; k_q <= '0;
				vld_q  <= '0;
			end
		end
	end

	// accumulator memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.upd_wr) mem[upd_addr] <= rd_val + ACC_W'(area_k);
		if (cmd.upd_rd || cmd.emit_rd) begin
			rd_q  <= mem[raddr];
			rdv_q <= vld_q[raddr];
		end
	end

	// n squared, one register after the multiply
	logic [2*N_W-1:0] nn_full;
	assign nn_full = n_eff * n_eff;

	// restoring divider, one quotient bit a cycle
	logic             ge;
	logic [ACC_W-1:0] rdiff;
	assign ge    = rem_q >= nn_q;
	assign rdiff = rem_q - (ge ? nn_q : '0);

	always_ff @(posedge clk) begin
		nn_q <= nn_full[ACC_W-1:0];
		if (cmd.emit_ld) begin
			rem_q  <= rd_val;
			area_q <= rd_val;
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= {rdiff[ACC_W-2:0], 1'b0};
			quo_q <= {quo_q[COV_W-2:0], ge};
		end
	end

	assign out_valid  = cmd.show;
	assign cell_x     = col_q;
	assign cell_y     = r_q[CELL_W-1:0];
	assign area_sum   = area_q;
	assign coverage   = quo_q;
	assign row_done   = col_last;
	assign frame_done = col_last && (r_q == (t_eff - T_W'(1)));
endmodule
`default_nettype wire

>>> hdl/binary_image_area_downsample_top.sv
// top level of the binary image area-averaging downsampler
// Usage: pixels of a square N by N binary image enter on in_valid/in_stall
// in raster order, one word per pixel. A word is taken when in_valid is high
// and in_stall low. When a source row completes a target row, the T cells of
// that row leave on out_valid/out_stall in column order, row_done on the
// last cell and frame_done on the last cell of the grid.
// A clear pixel takes only the advance step, a set pixel before that four
// read-modify-write passes on the accumulator memory. The last pixel of a
// source row also takes the row step. Each emitted cell takes a memory
// read, a load, the bit-serial coverage divider and then the result word,
// and waits out any output stall.
// in_stall is high whenever the block is busy or a result is waiting; while
// the receiver holds out_stall the result word holds and no pixel is taken.
// Reset sets N to 1024 and T to 32 and clears accumulators and counters
// through per-entry valid bits, with no clearing pass. Any configuration write
// restarts the frame in the same way; write only while idle.
`default_nettype none
module binary_image_area_downsample_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_index,
	input  wire logic [biad_pkg::N_W-1:0]       cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           pixel,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [biad_pkg::CELL_W-1:0]         cell_x,
	output logic [biad_pkg::CELL_W-1:0]         cell_y,
	output logic [biad_pkg::ACC_W-1:0]          area_sum,
	output logic [biad_pkg::COV_W-1:0]          coverage,
	output logic                                row_done,
	output logic                                frame_done
);
	biad_pkg::cmd_t cmd;
	biad_pkg::sts_t sts;

	biad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	biad_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel      (pixel),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.area_sum   (area_sum),
		.coverage   (coverage),
		.row_done   (row_done),
		.frame_done (frame_done)
	);
endmodule
`default_nettype wire

>>> hdl/biad_checker.sv
// port-level checker for the downsampler, bound to the top level
`default_nettype none
module biad_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic row_done,
	input wire logic frame_done
);
	// result word stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// no pixel taken while a result waits
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("pixel taken while result pending");

	// grid end is also a row end
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> row_done)
		else $error("frame_done without row_done");

	// a row in progress keeps the input closed
	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !row_done |=> in_stall)
		else $error("input opened in the middle of a row");

	// a taken pixel keeps the block busy for at least the next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open straight after a pixel word");
endmodule

bind binary_image_area_downsample_top biad_checker u_biad_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.row_done   (row_done),
	.frame_done (frame_done)
);
`default_nettype wire

>>> tb/area_downsample_checker.sv
// checker for the area downsampler: predicts the cell words and compares them
`timescale 1ns / 100ps
module area_downsample_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [biad_pkg::N_W-1:0]    cfg_data,
	input  wire logic                        in_valid,
	input  wire logic                        in_stall,
	input  wire logic                        pixel,
	input  wire logic                        out_valid,
	input  wire logic                        out_stall,
	input  wire logic [biad_pkg::CELL_W-1:0] cell_x,
	input  wire logic [biad_pkg::CELL_W-1:0] cell_y,
	input  wire logic [biad_pkg::ACC_W-1:0]  area_sum,
	input  wire logic [biad_pkg::COV_W-1:0]  coverage,
	input  wire logic                        row_done,
	input  wire logic                        frame_done,
	output int                               errors,
	output int                               pending
);
	typedef struct packed {
		logic [biad_pkg::CELL_W-1:0] x;
		logic [biad_pkg::CELL_W-1:0] y;
		logic [biad_pkg::ACC_W-1:0]  area;
		logic [biad_pkg::COV_W-1:0]  cov;
		logic                        rdone;
		logic                        fdone;
	} cell_word_t;

	cell_word_t expected_cells[$];
	logic [biad_pkg::ACC_W-1:0] coverage_acc[0:1][0:biad_pkg::TARGET_MAX-1];
	logic [biad_pkg::N_W-1:0]   side_reg;
	logic [biad_pkg::T_W-1:0]   grid_reg;
	longint unsigned            col_pos, row_pos, row_next;

	function automatic longint unsigned side_eff();
		longint unsigned n;
		n = side_reg;
		if (n == 0) n = 1;
		if (n > biad_pkg::SRC_MAX) n = biad_pkg::SRC_MAX;
		return n;
	endfunction

	function automatic longint unsigned grid_eff(longint unsigned n);
		longint unsigned t;
		t = grid_reg;
		if (t == 0) t = 1;
		if (t > biad_pkg::TARGET_MAX) t = biad_pkg::TARGET_MAX;
		if (t > n) t = n;
		return t;
	endfunction

	task automatic restart_frame();
		for (int b = 0; b < 2; b++)
			for (int c = 0; c < biad_pkg::TARGET_MAX; c++)
				coverage_acc[b][c] = '0;
		col_pos = 0;
		row_pos = 0;
		row_next = 0;
	endtask

	// first cell a pixel touches, and its overlap with that cell and the next
	task automatic overlap(input longint unsigned p, n, t,
			output longint unsigned c, w0, w1);
		longint unsigned s, e, bnd;
		s = p * t;
		e = s + t;
		c = s / n;
		bnd = (c + 1) * n;
		w0 = ((e < bnd) ? e : bnd) - s;
		w1 = t - w0;
	endtask

	task automatic add_area(longint unsigned cy, cx, t, a);
		if (a == 0 || cy >= t || cx >= t || cx >= biad_pkg::TARGET_MAX) return;
		coverage_acc[cy & 1][cx] = biad_pkg::ACC_W'(coverage_acc[cy & 1][cx] + a);
	endtask

	task automatic take_pixel(logic p);
		longint unsigned n, t, x, y, cx, wx0, wx1, cy, hy0, hy1, a;
		cell_word_t w;
		n = side_eff();
		t = grid_eff(n);
		x = (col_pos >= n) ? n - 1 : col_pos;
		y = (row_pos >= n) ? n - 1 : row_pos;
		if (p) begin
			overlap(x, n, t, cx, wx0, wx1);
			overlap(y, n, t, cy, hy0, hy1);
			add_area(cy, cx, t, wx0 * hy0);
			add_area(cy, cx + 1, t, wx1 * hy0);
			add_area(cy + 1, cx, t, wx0 * hy1);
			add_area(cy + 1, cx + 1, t, wx1 * hy1);
		end
		if (x + 1 < n) begin
			col_pos = x + 1;
			return;
		end
		col_pos = 0;
		if (row_next < t && (y + 1) * t >= (row_next + 1) * n) begin
			for (longint unsigned c = 0; c < t; c++) begin
				a = coverage_acc[row_next & 1][c];
				w.x = biad_pkg::CELL_W'(c);
				w.y = biad_pkg::CELL_W'(row_next);
				w.area = biad_pkg::ACC_W'(a);
				w.cov = biad_pkg::COV_W'((a << 16) / (n * n));
				w.rdone = (c + 1 == t);
				w.fdone = (c + 1 == t) && (row_next + 1 == t);
				expected_cells = {expected_cells, w};
				coverage_acc[row_next & 1][c] = '0;
			end
			row_next++;
		end
		if (y + 1 >= n)
			restart_frame();
		else
			row_pos = y + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_word_t exp_w, got;
		if (!arst_n) begin
			side_reg = biad_pkg::N_W'(1024);
			grid_reg = biad_pkg::T_W'(32);
			restart_frame();
			expected_cells.delete();
			errors <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == biad_pkg::REG_SRC_SIZE)
					side_reg = cfg_data;
				else
					grid_reg = cfg_data[biad_pkg::T_W-1:0];
				restart_frame();
			end
			if (in_valid && !in_stall)
				take_pixel(pixel);
			if (out_valid && !out_stall) begin
				got = '{cell_x, cell_y, area_sum, coverage, row_done, frame_done};
				if (expected_cells.size() == 0) begin
					if (errors < 10)
						$display("unexpected cell word x=%0d y=%0d area=%0d", cell_x, cell_y,
							area_sum);
					errors <= errors + 1;
				end else begin
					exp_w = expected_cells.pop_front();
					if (got !== exp_w) begin
						if (errors < 10)
							$display("cell mismatch exp x=%0d y=%0d area=%0d cov=%0d",
								exp_w.x, exp_w.y, exp_w.area, exp_w.cov,
								" rd=%b fd=%b, got x=%0d y=%0d area=%0d cov=%0d",
								exp_w.rdone, exp_w.fdone, got.x, got.y, got.area, got.cov,
								" rd=%b fd=%b", got.rdone, got.fdone);
						errors <= errors + 1;
					end
				end
			end
		end
		pending = expected_cells.size();
	end
endmodule

>>> tb/testbench.sv
// top of the area downsampler testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module testbench;
	logic                        clk, arst_n;
	logic                        cfg_we, cfg_index;
	logic [biad_pkg::N_W-1:0]    cfg_data;
	logic                        in_valid, in_stall, pixel;
	logic                        out_valid, out_stall;
	logic [biad_pkg::CELL_W-1:0] cell_x, cell_y;
	logic [biad_pkg::ACC_W-1:0]  area_sum;
	logic [biad_pkg::COV_W-1:0]  coverage;
	logic                        row_done, frame_done;
	int                          errors, pending;
	int                          idle_pct, stall_pct;

	binary_image_area_downsample_top dut (.*);
	area_downsample_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("testbench: FAIL");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_pixel(logic p);
		logic took;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		// in_stall is settled by the falling edge, so sample it there
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
	endtask

	// idle both ends of the block, then write one register
	task automatic write_reg(logic idx, int val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= biad_pkg::N_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_image(int pct, int count);
		for (int i = 0; i < count; i++)
			send_pixel($urandom_range(99) < pct);
	endtask

	initial begin
		int n, t, cnt;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = biad_pkg::REG_SRC_SIZE;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: a few pixels, no row completes
		send_pixel(1'b1);
		send_pixel(1'b0);
		send_pixel(1'b1);
		// one pixel per frame, zero target treated as one
		write_reg(biad_pkg::REG_SRC_SIZE, 1);
		write_reg(biad_pkg::REG_TARGET_SIZE, 0);
		send_pixel(1'b1);
		send_pixel(1'b0);
		// zero source size, oversized target clamped
		write_reg(biad_pkg::REG_SRC_SIZE, 0);
		write_reg(biad_pkg::REG_TARGET_SIZE, 127);
		send_pixel(1'b1);
		// largest source side, clamped from all ones
		write_reg(biad_pkg::REG_SRC_SIZE, 8191);
		write_reg(biad_pkg::REG_TARGET_SIZE, 64);
		send_image(50, 3);
		// pixels straddling two cells on both axes, full frame
		write_reg(biad_pkg::REG_SRC_SIZE, 3);
		write_reg(biad_pkg::REG_TARGET_SIZE, 2);
		send_image(100, 9);
		// target above source clamped to source
		write_reg(biad_pkg::REG_SRC_SIZE, 2);
		write_reg(biad_pkg::REG_TARGET_SIZE, 64);
		send_image(100, 4);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 54 : 26) : 0;
			stall_pct = (phase == 2) ? 54 : ((phase == 3) ? 26 : 0);
			cnt = 0;
			while (cnt < 40) begin
				n = $urandom_range(2, 9);
				t = ($urandom_range(9) == 0) ? 127 : $urandom_range(0, n + 1);
				write_reg(biad_pkg::REG_SRC_SIZE, n);
				write_reg(biad_pkg::REG_TARGET_SIZE, t);
				// mostly whole frames, now and then a broken one
				n = ($urandom_range(4) == 0) ? $urandom_range(1, n * n) : n * n;
				if (n > 40 - cnt) n = 40 - cnt;
				send_image($urandom_range(0, 100), n);
				cnt += n;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
